// ===== hw/rtl/mpv_pkg.sv =====
// mpv_pkg: shared types and constants of the mctp packet validator
// beat payloads, stored message state, register block and code values
// no dependencies
package mpv_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_EID_SLOTS = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OWN_EID_0          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_EID_1          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_EID_2          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_EID_3          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_PCI_VENDOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IANA_BIG_ENDIAN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IANA_LITTLE_ENDIAN = 3'd6;

  // message types
  localparam logic [6:0] KIND_CONTROL = 7'd0;
  localparam logic [6:0] KIND_PLDM    = 7'd1;
  localparam logic [6:0] KIND_SPDM    = 7'd5;
  localparam logic [6:0] KIND_PCI     = 7'd126;
  localparam logic [6:0] KIND_IANA    = 7'd127;

  localparam logic [3:0] HDR_VERSION_OK = 4'h1;
  localparam logic [7:0] EID_NULL       = 8'd0;
  localparam logic [7:0] EID_BROADCAST  = 8'd255;
  localparam logic [1:0] SEQ_ZERO       = 2'd0;

  localparam logic [1:0] CLASS_REQUEST  = 2'd0;
  localparam logic [1:0] CLASS_RESPONSE = 2'd1;

  localparam logic CMD_VALIDATE = 1'b0;
  localparam logic CMD_CLEAR    = 1'b1;

  // result codes
  localparam logic [3:0] ERR_OK         = 4'd0;
  localparam logic [3:0] ERR_VERSION    = 4'd1;
  localparam logic [3:0] ERR_INTERFACE  = 4'd2;
  localparam logic [3:0] ERR_EID        = 4'd3;
  localparam logic [3:0] ERR_CLASS      = 4'd4;
  localparam logic [3:0] ERR_VENDOR     = 4'd5;
  localparam logic [3:0] ERR_VENDOR_SEQ = 4'd6;
  localparam logic [3:0] ERR_TAG        = 4'd7;
  localparam logic [3:0] ERR_SEQUENCE   = 4'd8;

  typedef struct packed {
    logic        command;
    logic [3:0]  hdr_version;
    logic [2:0]  interface_id;
    logic [7:0]  dst_eid;
    logic [6:0]  message_kind;
    logic        start_flag;
    logic        end_flag;
    logic [2:0]  tag;
    logic [1:0]  sequence_req;
    logic [1:0]  packet_class;
    logic [15:0] pci_vendor;
    logic [31:0] iana_number;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] error_code;
    logic [6:0] active_kind;
  } out_item_t;

  typedef struct packed {
    logic [1:0] expected_sequence;
    logic [2:0] active_tag;
    logic [7:0] active_eid;
    logic [6:0] active_type;
  } state_t;

  typedef struct packed {
    logic [15:0] expected_pci_vendor;
    logic [31:0] iana_big_endian;
    logic [31:0] iana_little_endian;
  } cfg_t;

endpackage

// ===== hw/rtl/mpv_chan_if.sv =====
// mpv_chan_if: valid/ready channel carrying one beat of a given payload type
// used for both the header and the result channel; no dependencies
interface mpv_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mpv_cfg_regs.sv =====
// mpv_cfg_regs: register block of the validator (own eids, vendor ids)
// depends on mpv_pkg
module mpv_cfg_regs #(
  parameter int OWN_EID_SLOTS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mpv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpv_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [7:0]                    own_eid [OWN_EID_SLOTS],
  output mpv_pkg::cfg_t                 cfg
);
  import mpv_pkg::*;

  logic [7:0] own_eid_r [OWN_EID_SLOTS];
  cfg_t       cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < OWN_EID_SLOTS; i++) begin
        own_eid_r[i] <= '0;
      end
      cfg_r <= '0;
    end else if (cfg_we) begin
      // own eid slots sit at the lowest indexes
      for (int i = 0; i < OWN_EID_SLOTS; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          own_eid_r[i] <= cfg_data[7:0];
        end
      end
      case (cfg_index)
        REG_EXPECTED_PCI_VENDOR: cfg_r.expected_pci_vendor <= cfg_data[15:0];
        REG_IANA_BIG_ENDIAN:     cfg_r.iana_big_endian     <= cfg_data;
        REG_IANA_LITTLE_ENDIAN:  cfg_r.iana_little_endian  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign own_eid = own_eid_r;
  assign cfg     = cfg_r;

endmodule

// ===== hw/rtl/mpv_check.sv =====
// mpv_check: header checks and message state update for one beat
// purely combinational; depends on mpv_pkg
module mpv_check #(
  parameter int INTERFACE_COUNT = 4,
  parameter int OWN_EID_SLOTS   = 4
) (
  input  mpv_pkg::in_item_t  item,
  input  mpv_pkg::state_t    st,
  input  mpv_pkg::cfg_t      cfg,
  input  logic [7:0]         own_eid [OWN_EID_SLOTS],
  output mpv_pkg::state_t    st_nxt,
  output mpv_pkg::out_item_t res
);
  import mpv_pkg::*;

  logic       eok;
  logic       cls_ok;
  logic       ifc_ok;
  logic       iana_match;
  logic       som_only;
  logic [1:0] seq_inc;
  logic [3:0] err;

  always_comb begin
    eok = (item.dst_eid == EID_NULL) || (item.dst_eid == EID_BROADCAST);
    for (int i = 0; i < OWN_EID_SLOTS; i++) begin
      if (own_eid[i] == item.dst_eid) begin
        eok = 1'b1;
      end
    end
  end

  assign cls_ok     = item.packet_class inside {CLASS_REQUEST, CLASS_RESPONSE};
  assign ifc_ok     = 4'(item.interface_id) < 4'(INTERFACE_COUNT);
  assign iana_match = (item.iana_number == cfg.iana_big_endian) ||
                      (item.iana_number == cfg.iana_little_endian);
  assign som_only   = item.start_flag && !item.end_flag;
  assign seq_inc    = st.expected_sequence + 2'd1;

  always_comb begin
    st_nxt = st;
    err    = ERR_OK;
    if (item.command == CMD_CLEAR) begin
      st_nxt = '0;
    end else if (item.hdr_version != HDR_VERSION_OK) begin
      err = ERR_VERSION;
    end else if (!ifc_ok) begin
      err = ERR_INTERFACE;
    end else if (item.message_kind == KIND_CONTROL && item.start_flag && item.end_flag) begin
      if (!eok) begin
        err = ERR_EID;
      end else if (!cls_ok) begin
        err = ERR_CLASS;
      end else begin
        st_nxt.active_type = KIND_CONTROL;
      end
    end else if ((item.message_kind inside {KIND_PLDM, KIND_SPDM}) && item.start_flag) begin
      if (!eok) begin
        err = ERR_EID;
      end else begin
        st_nxt.active_type       = item.message_kind;
        st_nxt.active_tag        = item.tag;
        st_nxt.expected_sequence = item.sequence_req;
        st_nxt.active_eid        = item.dst_eid;
      end
    end else if (item.message_kind == KIND_PCI && item.start_flag) begin
      if (!eok) begin
        err = ERR_EID;
      end else if (item.pci_vendor != cfg.expected_pci_vendor) begin
        err = ERR_VENDOR;
      end
    end else if (item.message_kind == KIND_IANA && iana_match) begin
      if (!eok) begin
        err = ERR_EID;
      end else if (item.sequence_req != SEQ_ZERO) begin
        err = ERR_VENDOR_SEQ;
      end else if (!cls_ok) begin
        err = ERR_CLASS;
      end else begin
        st_nxt.active_type = KIND_IANA;
        if (som_only) begin
          st_nxt.active_tag        = item.tag;
          st_nxt.expected_sequence = item.sequence_req;
          st_nxt.active_eid        = item.dst_eid;
        end
      end
    end else begin
      // continuation of the stored message
      if (!eok || st.active_eid != item.dst_eid) begin
        err = ERR_EID;
      end else if (som_only) begin
        st_nxt.expected_sequence = item.sequence_req;
      end else if (item.tag != st.active_tag) begin
        err = ERR_TAG;
      end else begin
        // sequence advances even when the packet's number is wrong
        st_nxt.expected_sequence = seq_inc;
        if (item.sequence_req != seq_inc) begin
          err = ERR_SEQUENCE;
        end
      end
    end
  end

  assign res.accepted    = (err == ERR_OK);
  assign res.error_code  = err;
  assign res.active_kind = st_nxt.active_type;

endmodule

// ===== hw/rtl/mctp_packet_validator_core.sv =====
// mctp_packet_validator_core: top level of the mctp packet header validator
// depends on mpv_pkg, mpv_chan_if, mpv_cfg_regs and mpv_check
//
// Takes one header beat per cycle and returns one result beat for each, in
// order: accepted, a reason code and the message type now in progress. A beat
// lands in an input register, is checked by one stage of compares against the
// stored message state and the registers, and its result waits in an output
// register; the result is offered from there once the input beat has moved on and
// can leave at the following edge. The stored state is updated as a beat moves
// into the output register, so the next beat is checked against it in the
// following cycle. Throughput is one beat per cycle while the result side takes
// beats; if it stalls, the input register holds one more beat and then
// in_chan.ready drops. The user must write the registers through cfg_we/cfg_index/cfg_data
// only while no beat is in flight; the block itself does not enforce this.
module mctp_packet_validator_core #(
  parameter int INTERFACE_COUNT = 4,
  parameter int OWN_EID_SLOTS   = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mpv_chan_if.sink                       in_chan,
  mpv_chan_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [mpv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mpv_pkg::*;

  logic [7:0] own_eid [OWN_EID_SLOTS];
  cfg_t       cfg;

  in_item_t  in_item_r;
  logic      in_vld_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      out_vld_r;
  state_t    st_r;
  state_t    st_nxt;
  logic      advance;

  mpv_cfg_regs #(
    .OWN_EID_SLOTS (OWN_EID_SLOTS)
  ) u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .own_eid   (own_eid),
    .cfg       (cfg)
  );

  mpv_check #(
    .INTERFACE_COUNT (INTERFACE_COUNT),
    .OWN_EID_SLOTS   (OWN_EID_SLOTS)
  ) u_check (
    .item    (in_item_r),
    .st      (st_r),
    .cfg     (cfg),
    .own_eid (own_eid),
    .st_nxt  (st_nxt),
    .res     (out_item_nxt)
  );

  // a beat moves on when the output register is empty or being drained
  assign advance       = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
    end else begin
      if (in_chan.ready) begin
        in_vld_r <= in_chan.valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_item_r <= in_chan.payload;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_chan.valid   = out_vld_r;
  assign out_chan.payload = out_item_r;

endmodule

// ===== hw/rtl/mpv_checker.sv =====
// mpv_checker: port-level assertions for mctp_packet_validator_core
// bound to the top level below; depends on mpv_pkg
module mpv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_accepted,
  input logic [3:0] out_error_code,
  input logic [6:0] out_active_kind
);
  import mpv_pkg::*;

  // accept flag and reason code must agree
  a_accept_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_error_code == ERR_OK)))
    else $error("accepted flag disagrees with error code");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_code <= ERR_SEQUENCE))
    else $error("error code out of range");

  // only these types are ever recorded as the message in progress
  a_kind_recorded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_active_kind == KIND_CONTROL || out_active_kind == KIND_PLDM ||
                   out_active_kind == KIND_SPDM || out_active_kind == KIND_IANA))
    else $error("unexpected active message type");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_accepted, out_error_code, out_active_kind}))
    else $error("stalled result beat changed");

endmodule

bind mctp_packet_validator_core mpv_checker u_mpv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_accepted    (out_chan.payload.accepted),
  .out_error_code  (out_chan.payload.error_code),
  .out_active_kind (out_chan.payload.active_kind)
);

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for mctp_packet_validator_core
// needs mpv_pkg, mpv_chan_if and the validator rtl; predicts every verdict in step
// with the header stream and checks result beats in order under random gaps and stalls
`timescale 1ns / 100ps

module tb_top;
  import mpv_pkg::*;

  localparam int INTERFACE_COUNT = 4;
  localparam int OWN_EID_SLOTS   = 4;
  localparam int DRAIN_CYCLES    = 6;
  localparam int WATCHDOG_LIMIT  = 500;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mpv_chan_if #(.payload_t(in_item_t))  hdr_if ();
  mpv_chan_if #(.payload_t(out_item_t)) res_if ();

  mctp_packet_validator_core #(
    .INTERFACE_COUNT(INTERFACE_COUNT),
    .OWN_EID_SLOTS  (OWN_EID_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (hdr_if),
    .out_chan (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // register shadow
  logic [7:0]  own_eid_q [4];
  logic [15:0] pci_vendor_cfg;
  logic [31:0] iana_be_cfg;
  logic [31:0] iana_le_cfg;

  // shadow of the message in progress
  logic [1:0] msg_seq;
  logic [2:0] msg_tag;
  logic [7:0] msg_eid;
  logic [6:0] msg_kind;

  out_item_t verdict_q [$];
  int        mismatches;
  int        items_sent;
  int        idle_cycles;
  bit        gaps_on;

  always #5 clk = ~clk;

  function automatic void clear_msg_state();
    msg_seq  = SEQ_ZERO;
    msg_tag  = '0;
    msg_eid  = EID_NULL;
    msg_kind = KIND_CONTROL;
  endfunction

  function automatic out_item_t predict_verdict(input in_item_t h);
    out_item_t  r;
    logic [3:0] err;
    logic       eid_ok;
    logic       cls_ok;
    logic       iana_hit;
    err      = ERR_OK;
    eid_ok   = (h.dst_eid == EID_NULL) || (h.dst_eid == EID_BROADCAST);
    for (int i = 0; i < OWN_EID_SLOTS; i++)
      if (own_eid_q[i] == h.dst_eid) eid_ok = 1'b1;
    cls_ok   = (h.packet_class == CLASS_REQUEST) || (h.packet_class == CLASS_RESPONSE);
    iana_hit = (h.message_kind == KIND_IANA) &&
               ((h.iana_number == iana_be_cfg) || (h.iana_number == iana_le_cfg));

    if (h.command == CMD_CLEAR) begin
      clear_msg_state();
    end else if (h.hdr_version != HDR_VERSION_OK) begin
      err = ERR_VERSION;
    end else if (h.interface_id >= INTERFACE_COUNT) begin
      err = ERR_INTERFACE;
    end else if (h.message_kind == KIND_CONTROL && h.start_flag && h.end_flag) begin
      if (!eid_ok) err = ERR_EID;
      else if (!cls_ok) err = ERR_CLASS;
      else msg_kind = KIND_CONTROL;
    end else if ((h.message_kind == KIND_PLDM || h.message_kind == KIND_SPDM) &&
                 h.start_flag) begin
      if (!eid_ok) begin
        err = ERR_EID;
      end else begin
        msg_kind = h.message_kind;
        msg_tag  = h.tag;
        msg_seq  = h.sequence_req;
        msg_eid  = h.dst_eid;
      end
    end else if (h.message_kind == KIND_PCI && h.start_flag) begin
      if (!eid_ok) err = ERR_EID;
      else if (h.pci_vendor != pci_vendor_cfg) err = ERR_VENDOR;
    end else if (iana_hit) begin
      if (!eid_ok) begin
        err = ERR_EID;
      end else if (h.sequence_req != SEQ_ZERO) begin
        err = ERR_VENDOR_SEQ;
      end else if (!cls_ok) begin
        err = ERR_CLASS;
      end else begin
        msg_kind = KIND_IANA;
        if (h.start_flag && !h.end_flag) begin
          msg_tag = h.tag;
          msg_seq = h.sequence_req;
          msg_eid = h.dst_eid;
        end
      end
    // everything else continues the stored message
    end else if (!eid_ok || msg_eid != h.dst_eid) begin
      err = ERR_EID;
    end else if (h.start_flag && !h.end_flag) begin
      msg_seq = h.sequence_req;
    end else if (h.tag != msg_tag) begin
      err = ERR_TAG;
    end else begin
      msg_seq = msg_seq + 2'd1;
      if (h.sequence_req != msg_seq) err = ERR_SEQUENCE;
    end

    r.accepted    = (err == ERR_OK);
    r.error_code  = err;
    r.active_kind = msg_kind;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if ((hdr_if.valid && hdr_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
    if (res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing pending", got));
      end else begin
        want = verdict_q.pop_front();
        if (got.accepted !== want.accepted)
          report_mismatch($sformatf("accepted %b, want %b", got.accepted, want.accepted));
        if (got.error_code !== want.error_code)
          report_mismatch($sformatf("error_code %0d, want %0d",
                                    got.error_code, want.error_code));
        if (got.active_kind !== want.active_kind)
          report_mismatch($sformatf("active_kind %0d, want %0d",
                                    got.active_kind, want.active_kind));
      end
    end
  end

  // result side: random stall bursts while gaps are on
  initial begin
    res_if.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      res_if.ready <= 1'b1;
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken,
  // leaving valid high so back-to-back beats need no extra step
  task automatic send_header(input in_item_t h);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      hdr_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    hdr_if.valid   <= 1'b1;
    hdr_if.payload <= h;
    do @(posedge clk); while (!hdr_if.ready);
    verdict_q.push_back(predict_verdict(h));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    hdr_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // narrow registers get random junk above their width
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] junk;
    logic [31:0] drive;
    junk  = $urandom;
    drive = value;
    case (idx)
      REG_OWN_EID_0, REG_OWN_EID_1, REG_OWN_EID_2, REG_OWN_EID_3: begin
        drive = {junk[31:8], value[7:0]};
        own_eid_q[idx[1:0]] = value[7:0];
      end
      REG_EXPECTED_PCI_VENDOR: begin
        drive = {junk[31:16], value[15:0]};
        pci_vendor_cfg = value[15:0];
      end
      REG_IANA_BIG_ENDIAN:    iana_be_cfg = value;
      REG_IANA_LITTLE_ENDIAN: iana_le_cfg = value;
      default: ;
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= drive;
    @(negedge clk);
  endtask

  task automatic write_all_regs(input logic [7:0] e0, input logic [7:0] e1,
                                input logic [7:0] e2, input logic [7:0] e3,
                                input logic [15:0] vendor,
                                input logic [31:0] be, input logic [31:0] le);
    wait_results_drained();
    write_reg(REG_OWN_EID_0, {24'd0, e0});
    write_reg(REG_OWN_EID_1, {24'd0, e1});
    write_reg(REG_OWN_EID_2, {24'd0, e2});
    write_reg(REG_OWN_EID_3, {24'd0, e3});
    write_reg(REG_EXPECTED_PCI_VENDOR, {16'd0, vendor});
    write_reg(REG_IANA_BIG_ENDIAN, be);
    write_reg(REG_IANA_LITTLE_ENDIAN, le);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t make_header(input logic [6:0] kind, input logic [7:0] dst,
                                           input logic som, input logic eom,
                                           input logic [2:0] tag, input logic [1:0] seq);
    in_item_t h;
    h              = '0;
    h.command      = CMD_VALIDATE;
    h.hdr_version  = HDR_VERSION_OK;
    h.interface_id = 3'($urandom_range(0, INTERFACE_COUNT - 1));
    h.dst_eid      = dst;
    h.message_kind = kind;
    h.start_flag   = som;
    h.end_flag     = eom;
    h.tag          = tag;
    h.sequence_req = seq;
    h.packet_class = 2'($urandom_range(0, 1));
    h.pci_vendor   = pci_vendor_cfg;
    h.iana_number  = $urandom;
    return h;
  endfunction

  function automatic logic [7:0] pick_good_eid();
    case ($urandom_range(0, 5))
      0: return EID_NULL;
      1: return EID_BROADCAST;
      default: return own_eid_q[2'($urandom_range(0, OWN_EID_SLOTS - 1))];
    endcase
  endfunction

  function automatic logic [31:0] pick_iana();
    return $urandom_range(0, 1) ? iana_be_cfg : iana_le_cfg;
  endfunction

  // start, middles, end; one packet may be damaged
  task automatic send_message(input logic [6:0] kind, input int middles, input bit corrupt);
    in_item_t   h;
    logic [7:0] dst;
    logic [2:0] tag;
    logic [1:0] seq;
    int         bad;
    dst = pick_good_eid();
    tag = 3'($urandom);
    seq = (kind == KIND_IANA) ? SEQ_ZERO : 2'($urandom);
    bad = corrupt ? int'($urandom_range(0, middles + 1)) : -1;
    for (int i = 0; i <= middles + 1; i++) begin
      if (i == 0) begin
        h = make_header(kind, dst, 1'b1, 1'b0, tag, seq);
        if (kind == KIND_IANA) h.iana_number = pick_iana();
      end else begin
        h = make_header($urandom_range(0, 2) == 0 ? 7'($urandom_range(2, 4)) : kind,
                        dst, 1'b0, i == middles + 1, tag, seq + 2'(i));
      end
      if (i == bad) begin
        case ($urandom_range(0, 5))
          0: h.tag          = h.tag + 3'($urandom_range(1, 7));
          1: h.sequence_req = h.sequence_req + 2'($urandom_range(1, 3));
          2: h.dst_eid      = 8'($urandom);
          3: h.hdr_version  = 4'($urandom);
          4: h.interface_id = 3'($urandom_range(INTERFACE_COUNT, 7));
          default: h.start_flag = 1'b1;
        endcase
      end
      send_header(h);
    end
  endtask

  task automatic run_random_items(input int count);
    in_item_t h;
    int       pick;
    int       target;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_message($urandom_range(0, 1) ? KIND_PLDM : KIND_SPDM,
                     $urandom_range(0, 4), $urandom_range(0, 4) == 0);
      end else if (pick < 55) begin
        // single-packet pldm or spdm
        send_header(make_header($urandom_range(0, 1) ? KIND_PLDM : KIND_SPDM,
                                pick_good_eid(), 1'b1, 1'b1, 3'($urandom), 2'($urandom)));
      end else if (pick < 63) begin
        send_message(KIND_IANA, $urandom_range(0, 3), $urandom_range(0, 4) == 0);
      end else if (pick < 70) begin
        h = make_header(KIND_IANA, pick_good_eid(), 1'($urandom), 1'($urandom),
                        3'($urandom), $urandom_range(0, 3) == 0 ? 2'($urandom) : SEQ_ZERO);
        h.iana_number  = pick_iana();
        h.packet_class = $urandom_range(0, 4) == 0 ? 2'($urandom) : h.packet_class;
        send_header(h);
      end else if (pick < 77) begin
        h = make_header(KIND_PCI, pick_good_eid(), 1'b1, 1'($urandom), 3'($urandom),
                        2'($urandom));
        if ($urandom_range(0, 3) == 0) h.pci_vendor = 16'($urandom);
        send_header(h);
      end else if (pick < 84) begin
        h = make_header(KIND_CONTROL, $urandom_range(0, 3) == 0 ? 8'($urandom)
                                                                 : pick_good_eid(),
                        1'b1, 1'b1, 3'($urandom), 2'($urandom));
        h.packet_class = 2'($urandom);
        send_header(h);
      end else if (pick < 88) begin
        h         = make_header(KIND_CONTROL, EID_NULL, 1'b0, 1'b0, 3'd0, SEQ_ZERO);
        h.command = CMD_CLEAR;
        h.dst_eid = 8'($urandom);
        send_header(h);
      end else begin
        // raw noise, every field random
        h.command      = ($urandom_range(0, 7) == 0) ? CMD_CLEAR : CMD_VALIDATE;
        h.hdr_version  = $urandom_range(0, 1) ? HDR_VERSION_OK : 4'($urandom);
        h.interface_id = 3'($urandom);
        h.dst_eid      = 8'($urandom);
        h.message_kind = 7'($urandom);
        h.start_flag   = 1'($urandom);
        h.end_flag     = 1'($urandom);
        h.tag          = 3'($urandom);
        h.sequence_req = 2'($urandom);
        h.packet_class = 2'($urandom);
        h.pci_vendor   = 16'($urandom);
        h.iana_number  = $urandom;
        send_header(h);
      end
    end
  endtask

  // reset values of every register, iana zero matches too
  task automatic test_reset_defaults();
    run_random_items(80);
  endtask

  task automatic test_directed_headers();
    in_item_t h;
    write_all_regs(8'h10, 8'h20, 8'h30, 8'h40, 16'h1AB4, 32'h0000_0A5C, 32'h5C0A_0000);
    h = make_header(KIND_CONTROL, EID_NULL, 1'b1, 1'b1, 3'd0, SEQ_ZERO);
    h.hdr_version = 4'h0;
    send_header(h);
    h.hdr_version = 4'hF;
    send_header(h);
    h = make_header(KIND_CONTROL, EID_NULL, 1'b1, 1'b1, 3'd0, SEQ_ZERO);
    h.interface_id = 3'd7;
    send_header(h);
    h.interface_id = 3'(INTERFACE_COUNT - 1);
    h.packet_class = CLASS_REQUEST;
    send_header(h);
    h.dst_eid      = EID_BROADCAST;
    h.packet_class = CLASS_RESPONSE;
    send_header(h);
    h.dst_eid = 8'h41;
    send_header(h);
    h.dst_eid      = 8'h40;
    h.packet_class = 2'd3;
    send_header(h);
    // pldm message: sequence wraps, then bad tag, bad sequence, foreign eid
    send_header(make_header(KIND_PLDM, 8'h10, 1'b1, 1'b0, 3'd5, 2'd3));
    send_header(make_header(KIND_PLDM, 8'h10, 1'b0, 1'b0, 3'd5, 2'd0));
    send_header(make_header(KIND_PLDM, 8'h10, 1'b0, 1'b0, 3'd4, 2'd1));
    send_header(make_header(KIND_PLDM, 8'h10, 1'b0, 1'b0, 3'd5, 2'd3));
    send_header(make_header(KIND_PLDM, 8'h20, 1'b0, 1'b1, 3'd5, 2'd2));
    // start without end on an unknown type restarts the sequence only
    send_header(make_header(7'd2, 8'h10, 1'b1, 1'b0, 3'd1, 2'd2));
    send_header(make_header(7'd2, 8'h10, 1'b0, 1'b1, 3'd5, 2'd3));
    send_header(make_header(KIND_SPDM, 8'h40, 1'b1, 1'b1, 3'd7, 2'd0));
    h = make_header(KIND_PCI, 8'h30, 1'b1, 1'b1, 3'd0, 2'd0);
    send_header(h);
    h.pci_vendor = ~pci_vendor_cfg;
    send_header(h);
    // pci without start bit continues the spdm message
    send_header(make_header(KIND_PCI, 8'h40, 1'b0, 1'b1, 3'd7, 2'd1));
    h = make_header(KIND_IANA, EID_BROADCAST, 1'b1, 1'b1, 3'd0, SEQ_ZERO);
    h.iana_number  = iana_be_cfg;
    h.packet_class = CLASS_REQUEST;
    send_header(h);
    h.iana_number  = iana_le_cfg;
    h.sequence_req = 2'd1;
    send_header(h);
    h.sequence_req = SEQ_ZERO;
    h.packet_class = 2'd3;
    send_header(h);
    h = make_header(KIND_IANA, 8'h20, 1'b1, 1'b0, 3'd2, SEQ_ZERO);
    h.iana_number = iana_be_cfg;
    send_header(h);
    // multi-packet control falls through to the stored message
    send_header(make_header(KIND_CONTROL, 8'h20, 1'b1, 1'b0, 3'd2, 2'd3));
    h.command = CMD_CLEAR;
    send_header(h);
    send_header(make_header(7'h55, EID_NULL, 1'b0, 1'b1, 3'd0, 2'd1));
  endtask

  task automatic test_random_configs();
    for (int s = 0; s < 5; s++) begin
      case (s)
        0: write_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          16'($urandom), $urandom, $urandom);
        2: write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'h00, 16'h0000,
                          32'h1234_5678, 32'h7856_3412);
        3: write_all_regs(8'h01, 8'hFE, 8'h80, 8'h7F, 16'h8000, 32'h8000_0001,
                          32'h0100_0080);
        default: write_all_regs(8'($urandom), 8'($urandom), 8'h00, 8'($urandom),
                                16'($urandom), $urandom, 32'h0000_0000);
      endcase
      run_random_items(85);
      // hold the header side until every pending verdict is back
      wait_results_drained();
      run_random_items(85);
    end
  endtask

  task automatic test_no_gaps();
    write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom), $urandom, $urandom);
    gaps_on = 1'b0;
    run_random_items(100);
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    hdr_if.valid   = 1'b0;
    hdr_if.payload = '0;
    mismatches     = 0;
    items_sent     = 0;
    idle_cycles    = 0;
    gaps_on        = 1'b1;
    for (int i = 0; i < 4; i++) own_eid_q[i] = 8'h00;
    pci_vendor_cfg = '0;
    iana_be_cfg    = '0;
    iana_le_cfg    = '0;
    clear_msg_state();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_directed_headers();
    test_random_configs();
    test_no_gaps();

    wait_results_drained();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mpv_pkg.sv
hw/rtl/mpv_chan_if.sv
hw/rtl/mpv_cfg_regs.sv
hw/rtl/mpv_check.sv
hw/rtl/mctp_packet_validator_core.sv
hw/rtl/mpv_checker.sv
test/tb_top.sv
